FILE: rtl/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash core.
// Depends on nothing; used by every module in rtl.
`timescale 1ns / 1ps
package sha1_pkg;
	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hefcdab89;
	localparam logic [31:0] H2_INIT = 32'h98badcfe;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;
	localparam logic [31:0] PAD_WORD = 32'h80000000;
	localparam int QDEPTH = 4;

	// One word of a block as passed from the front end to the engine.
	typedef struct packed {
		logic [31:0] word;
		logic        final_word; // last word of the message
	} blk_word_t;

	typedef enum logic [2:0] {
		FE_MSG, FE_PAD80, FE_ZERO, FE_LEN_HI, FE_LEN_LO
	} fe_state_t;

	typedef enum logic [1:0] {
		BE_LOAD, BE_ROUND, BE_ADD, BE_OUT
	} be_state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction
endpackage

FILE: rtl/sha1_front.sv
// Front end: takes message words, applies padding and length, feeds block words.
// Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_front import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] in_word,
	input  logic [2:0]  in_bytes,
	input  logic        in_last,
	output logic        o_valid,
	input  logic        o_ready,
	output blk_word_t   o_data
);
	fe_state_t state_q, state_d;
	logic [3:0]  cnt_q;
	logic [63:0] len_q;
	logic [2:0]  nb;
	logic [31:0] mask, padded;
	logic [63:0] len_add;

	always_comb begin
		// Only the last word of a message carries a partial byte count.
		nb = (!in_last || in_bytes > 3'd4) ? 3'd4 : in_bytes;
		unique case (nb)
			3'd0: mask = 32'h00000000;
			3'd1: mask = 32'hff000000;
			3'd2: mask = 32'hffff0000;
			3'd3: mask = 32'hffffff00;
			default: mask = 32'hffffffff;
		endcase
		unique case (nb)
			3'd0: padded = 32'h80000000;
			3'd1: padded = (in_word & mask) | 32'h00800000;
			3'd2: padded = (in_word & mask) | 32'h00008000;
			3'd3: padded = (in_word & mask) | 32'h00000080;
			default: padded = in_word;
		endcase
		len_add = len_q + {58'd0, (in_last ? nb : 3'd4), 3'd0};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_MSG: if (in_valid && o_ready && in_last)
				state_d = (nb == 3'd4) ? FE_PAD80
					: ((cnt_q == 4'd13) ? FE_LEN_HI : FE_ZERO);
			FE_PAD80: if (o_ready) state_d = (cnt_q == 4'd13) ? FE_LEN_HI : FE_ZERO;
			FE_ZERO: if (o_ready && cnt_q == 4'd13) state_d = FE_LEN_HI;
			FE_LEN_HI: if (o_ready) state_d = FE_LEN_LO;
			FE_LEN_LO: if (o_ready) state_d = FE_MSG;
			default: state_d = FE_MSG;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		o_valid = 1'b1;
		o_data.final_word = 1'b0;
		o_data.word = 32'd0;
		unique case (state_q)
			FE_MSG: begin
				in_ready = o_ready;
				o_valid = in_valid;
				o_data.word = padded;
			end
			FE_PAD80: o_data.word = PAD_WORD;
			FE_ZERO: o_data.word = 32'd0;
			FE_LEN_HI: o_data.word = len_q[63:32];
			FE_LEN_LO: begin
				o_data.word = len_q[31:0];
				o_data.final_word = 1'b1;
			end
			default: o_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_MSG;
			cnt_q <= '0;
			len_q <= '0;
		end else begin
			state_q <= state_d;
			if (o_valid && o_ready) cnt_q <= cnt_q + 4'd1;
			if (in_valid && in_ready) len_q <= len_add;
			else if (state_q == FE_LEN_LO && o_ready) len_q <= '0;
		end
	end
endmodule

FILE: rtl/sha1_fifo.sv
// Short queue that decouples the front end from the compression engine.
// Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_fifo import sha1_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      w_valid,
	output logic      w_ready,
	input  blk_word_t w_data,
	output logic      r_valid,
	input  logic      r_ready,
	output blk_word_t r_data
);
	blk_word_t mem_q [QDEPTH];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;

	assign w_ready = cnt_q != 3'(QDEPTH);
	assign r_valid = cnt_q != 3'd0;
	assign r_data = mem_q[rp_q];
	assign wr = w_valid && w_ready;
	assign rd = r_valid && r_ready;

	always_ff @(posedge clk) if (wr) mem_q[wp_q] <= w_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, rd};
		end
	end

`ifndef ASSERT_OFF
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'(QDEPTH)) else $error("queue count overflow");
	a_wr_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 3'd1) else $error("count not raised");
	a_rd_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> cnt_q == $past(cnt_q) - 3'd1) else $error("count not lowered");
`endif
endmodule

FILE: rtl/sha1_engine.sv
// Compression engine: gathers 16 words, runs 80 rounds, chains, emits digest.
// Depends on sha1_pkg.
`timescale 1ns / 1ps
module sha1_engine import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        i_valid,
	output logic        i_ready,
	input  blk_word_t   i_data,
	output logic        o_valid,
	input  logic        o_ready,
	output logic [31:0] o_word,
	output logic [2:0]  o_index,
	output logic        o_last
);
	be_state_t state_q, state_d;
	logic [31:0] w_q [16];
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic [3:0]  wc_q;
	logic [2:0]  oi_q;
	logic        fin_q;
	logic [31:0] wt, f, k, tmp;
	logic        take;

	assign take = i_valid && i_ready;
	assign i_ready = state_q == BE_LOAD;
	assign o_valid = state_q == BE_OUT;
	assign o_word = h_q[oi_q];
	assign o_index = oi_q;
	assign o_last = oi_q == 3'd4;

	// Window is kept as a shift line: w_q[0] is the word for rounds below 16, and W[t-16] after that.
	always_comb begin
		wt = (rnd_q < 7'd16) ? w_q[0] : rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q); k = K0;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q; k = K1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = K2;
		end else begin
			f = b_q ^ c_q ^ d_q; k = K3;
		end
		tmp = rotl(a_q, 5) + f + e_q + wt + k;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BE_LOAD: if (take && wc_q == 4'd15) state_d = BE_ROUND;
			BE_ROUND: if (rnd_q == 7'd79) state_d = BE_ADD;
			BE_ADD: state_d = fin_q ? BE_OUT : BE_LOAD;
			BE_OUT: if (o_ready && oi_q == 3'd4) state_d = BE_LOAD;
			default: state_d = BE_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= i_data.word;
		end else if (state_q == BE_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wt;
		end
		if (state_q == BE_LOAD) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
		end else if (state_q == BE_ROUND) begin
			a_q <= tmp; b_q <= a_q; c_q <= rotl(b_q, 30); d_q <= c_q; e_q <= d_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BE_LOAD;
			rnd_q <= '0; wc_q <= '0; oi_q <= '0; fin_q <= 1'b0;
			h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
		end else begin
			state_q <= state_d;
			if (take) begin
				wc_q <= wc_q + 4'd1;
				fin_q <= i_data.final_word;
			end
			if (state_q == BE_ROUND) rnd_q <= (rnd_q == 7'd79) ? 7'd0 : rnd_q + 7'd1;
			if (state_q == BE_ADD) begin
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
			end
			if (state_q == BE_OUT && o_ready) begin
				oi_q <= (oi_q == 3'd4) ? 3'd0 : oi_q + 3'd1;
				if (oi_q == 3'd4) begin
					h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
					h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != BE_ROUND |-> rnd_q == 7'd0) else $error("round count stray");
	a_blk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BE_LOAD && state_d == BE_ROUND) |-> wc_q == 4'd15)
		else $error("short block");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		oi_q <= 3'd4) else $error("digest index out of range");
`endif
endmodule

FILE: rtl/sha1_hash_core_unit.sv
// Top level of the SHA-1 hash core: front end, queue and compression engine.
// Depends on sha1_pkg, sha1_front, sha1_fifo and sha1_engine.
`timescale 1ns / 1ps
// Each 16-word block is loaded word by word, the engine runs 80 rounds, one round
// per cycle, and a chaining step adds the result into the hash state; the front
// end and queue take words while the engine runs rounds. On the last word the
// padding and 64-bit length are added and five digest words follow, H0 first, the
// fifth marked by tlast. The chain then restarts for the next message.
module sha1_hash_core_unit import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // data_word[31:0], valid_bytes[34:32], zero fill
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic        m_tlast
);
	logic      fv, fr, ev, er;
	blk_word_t fd, ed;
	logic [31:0] dw;
	logic [2:0]  di;

	sha1_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_word(s_tdata[31:0]), .in_bytes(s_tdata[34:32]), .in_last(s_tlast),
		.o_valid(fv), .o_ready(fr), .o_data(fd));
	sha1_fifo u_fifo (.clk, .arst_n, .w_valid(fv), .w_ready(fr), .w_data(fd),
		.r_valid(ev), .r_ready(er), .r_data(ed));
	sha1_engine u_eng (.clk, .arst_n, .i_valid(ev), .i_ready(er), .i_data(ed),
		.o_valid(m_tvalid), .o_ready(m_tready), .o_word(dw), .o_index(di),
		.o_last(m_tlast));

	assign m_tdata = {5'd0, di, dw};
endmodule

FILE: dv/sha1_digest_checker.sv
// Checker for the SHA-1 hash core: watches both streams, predicts digests, compares.
// Depends on sha1_pkg for the round and initial constants.
`timescale 1ns / 1ps
module sha1_digest_checker import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic [31:0] digest;
		logic [2:0]  index;
		logic        fin;
	} digest_word_t;

	digest_word_t digest_q[$];
	logic [31:0] chain[5];
	logic [31:0] blk[16];
	int unsigned fill;
	logic [63:0] msg_bits;

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w[16];
		logic [31:0] a, b, c, d, e, f, k, wt, t;
		for (int i = 0; i < 16; i++) w[i] = blk[i];
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) wt = w[r];
			else begin
				wt = rol(w[(r-3)&15] ^ w[(r-8)&15] ^ w[(r-14)&15] ^ w[r&15], 1);
				w[r&15] = wt;
			end
			if (r < 20) begin f = (b & c) | (~b & d); k = K0; end
			else if (r < 40) begin f = b ^ c ^ d; k = K1; end
			else if (r < 60) begin f = (b & c) | (b & d) | (c & d); k = K2; end
			else begin f = b ^ c ^ d; k = K3; end
			t = rol(a, 5) + f + e + wt + k;
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
	endtask

	task automatic add_word(input logic [31:0] w);
		blk[fill] = w;
		fill++;
		if (fill == 16) begin
			compress();
			fill = 0;
		end
	endtask

	task automatic restart_chain();
		chain = '{H0_INIT, H1_INIT, H2_INIT, H3_INIT, H4_INIT};
		fill = 0;
		msg_bits = '0;
	endtask

	task automatic absorb_word(input logic [31:0] data, input logic [2:0] nb_in,
			input logic fin);
		int unsigned nb;
		logic [31:0] mask;
		if (!fin) begin
			msg_bits += 32;
			add_word(data);
			return;
		end
		nb = (nb_in > 4) ? 4 : nb_in;
		msg_bits += nb * 8;
		if (nb == 4) begin
			add_word(data);
			add_word(PAD_WORD);
		end else begin
			mask = (nb == 0) ? 32'h0 : (32'hffffffff << (8 * (4 - nb)));
			add_word((data & mask) | (32'h80 << (8 * (3 - nb))));
		end
		while (fill != 14) add_word(32'h0);
		add_word(msg_bits[63:32]);
		add_word(msg_bits[31:0]);
		for (int i = 0; i < 5; i++)
			digest_q.push_back('{chain[i], 3'(i), i == 4});
		restart_chain();
	endtask

	initial begin
		errors = 0;
		restart_chain();
	end

	assign pending = digest_q.size();

	always @(posedge clk) begin
		digest_word_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				absorb_word(s_tdata[31:0], s_tdata[34:32], s_tlast);
			if (m_tvalid && m_tready) begin
				if (digest_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("Unexpected digest transfer: %h last %b", m_tdata, m_tlast);
				end else begin
					want = digest_q.pop_front();
					if (m_tdata !== {5'b0, want.index, want.digest} || m_tlast !== want.fin) begin
						errors++;
						if (errors <= 10)
							$display("Digest mismatch: expected %h idx %0d last %b, got %h last %b",
								want.digest, want.index, want.fin, m_tdata, m_tlast);
					end
				end
			end
		end
	end
endmodule

FILE: dv/sha1_hash_core_unit_test.sv
// Top of the SHA-1 hash core testbench: clock, reset, message stimulus and verdict.
// Depends on sha1_hash_core_unit and sha1_digest_checker.
`timescale 1ns / 1ps
module sha1_hash_core_unit_test;
	localparam int STALL_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [39:0] s_tdata = '0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [39:0] m_tdata;
	logic m_tlast;
	int errors, pending;
	int idle_pct = 25;
	int idle_cycles;
	bit hold_sink = 0;
	bit done = 0;

	always #5 clk = ~clk;

	sha1_hash_core_unit DUT (.*);
	sha1_digest_checker checker_i (.*);

	task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic fin);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 0;
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'b0, nb, data};
		s_tlast <= fin;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Non-last words carry a random byte count, which the block must ignore.
	task automatic send_message(input int nwords, input logic [2:0] last_nb);
		for (int i = 0; i < nwords - 1; i++)
			send_word($urandom, 3'($urandom_range(7)), 1'b0);
		send_word($urandom, last_nb, 1'b1);
	endtask

	always @(negedge clk) begin
		if (hold_sink) m_tready <= 0;
		else m_tready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int wait_cnt;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// Directed: extreme data, every byte count, padding crossing block edges.
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'hffffffff, 3'd4, 1'b1);
		send_word(32'hffffffff, 3'd7, 1'b1);
		send_word(32'hffffffff, 3'd5, 1'b1);
		send_word(32'hffffffff, 3'd6, 1'b1);
		send_word(32'h61626300, 3'd3, 1'b1);
		send_word(32'hffffffff, 3'd1, 1'b1);
		send_word(32'hffffffff, 3'd2, 1'b1);
		send_message(14, 3'd4);
		send_message(14, 3'd3);
		send_message(16, 3'd0);
		send_message(17, 3'd4);
		// Receiver held off while messages keep coming, to fill the block up.
		hold_sink = 1;
		fork
			begin
				repeat (1500) @(posedge clk);
				@(negedge clk);
				hold_sink = 0;
			end
			begin
				for (int m = 0; m < 8; m++) send_message(1, 3'($urandom_range(4)));
			end
		join
		// Random messages, with one stretch of no idling.
		for (int m = 0; m < 43; m++) begin
			idle_pct = (m >= 20 && m < 32) ? 0 : 25;
			if ($urandom_range(9) == 0)
				send_message($urandom_range(20, 40), 3'($urandom_range(7)));
			else
				send_message($urandom_range(1, 8), 3'($urandom_range(7)));
		end
		idle_pct = 25;
		s_tvalid <= 0;
		s_tlast <= 0;
		wait_cnt = 0;
		while (pending != 0 && wait_cnt < 50000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
